FILE: hdl/pls_pkg.sv
// Shared types, codes and defaults for the pooled linked stack.
`timescale 1ns / 1ps

package pls_pkg;

    // Default number of node slots in the pool
    localparam int POOL_NODES_DEF = 8;

    // Operation codes carried by the mode field
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;    // capture the accepted input transaction
        logic exec_push;  // allocate a slot and link it in front
        logic pop_start;  // read the head slot's link
        logic pop_link;   // free the head slot, move head to successor, read its value
        logic pop_val;    // load new top value
        logic emit_res;   // load the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic empty;      // list holds no nodes
    } stat_t;

endpackage

FILE: hdl/pls_ctrl.sv
// Controller state machine: sequences push and pop and runs both handshakes.
`timescale 1ns / 1ps

module pls_ctrl
    import pls_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  mode,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PUSH     = 3'd1;
    localparam logic [2:0] S_POP      = 3'd2;
    localparam logic [2:0] S_POP_LINK = 3'd3;
    localparam logic [2:0] S_POP_VAL  = 3'd4;
    localparam logic [2:0] S_RESP     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_take;
    logic       out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign in_take  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = (mode == MODE_PUSH) ? S_PUSH : S_POP;
                end
            end
            S_PUSH:
            begin
                cmd.exec_push = 1'b1;
                state_next    = S_RESP;
            end
            S_POP:
            begin
                cmd.pop_start = 1'b1;
                state_next    = stat.empty ? S_RESP : S_POP_LINK;
            end
            S_POP_LINK:
            begin
                cmd.pop_link = 1'b1;
                state_next   = S_POP_VAL;
            end
            S_POP_VAL:
            begin
                cmd.pop_val = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    cmd.emit_res   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A pending result is never overwritten while it waits
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && out_valid_reg && !out_ready) |=> (state_reg == S_RESP))
        else $error("result stage left while output still stalled");

    // Results are only issued from the response state
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && out_valid_next) |-> (state_reg == S_RESP))
        else $error("output valid raised outside response state");

endmodule

FILE: hdl/pls_datapath.sv
// Datapath: free map, head register, node memories and result registers.
`timescale 1ns / 1ps

module pls_datapath
    import pls_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic               mode,
    input  logic signed [31:0] push_value,
    output logic [1:0]         status,
    output logic [2:0]         slot_used,
    output logic               list_empty,
    output logic signed [31:0] top_value
);

    localparam int LW = $clog2(POOL_NODES + 1);
    localparam int SW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_NODES);

    // Node memories
    logic [31:0]     value_mem [POOL_NODES];
    logic [LW-1:0]   link_mem  [POOL_NODES];

    // Control state
    logic [POOL_NODES-1:0] free_map_reg;
    logic [LW-1:0]         head_reg;
    logic signed [31:0]    top_reg;

    // Transaction and result registers
    logic               mode_reg;
    logic signed [31:0] value_reg;
    logic [1:0]         res_status_reg;
    logic [SW-1:0]      res_slot_reg;
    logic [LW-1:0]      link_rd_reg;
    logic [31:0]        val_rd_reg;
    logic [1:0]         out_status_reg;
    logic [2:0]         out_slot_reg;
    logic               out_empty_reg;
    logic signed [31:0] out_top_reg;

    logic [SW-1:0]      free_slot;
    logic               found;
    logic               head_null;
    logic               next_null;
    logic [SW-1:0]      head_idx;
    logic [SW+2:0]      slot_ext;

    assign head_null  = (head_reg >= NULL_LINK);
    assign next_null  = (link_rd_reg >= NULL_LINK);
    assign head_idx   = head_reg[SW-1:0];
    assign stat.empty = head_null;
    assign slot_ext   = {3'b000, res_slot_reg};

    // Lowest-numbered free slot
    always_comb
    begin
        free_slot = '0;
        found     = 1'b0;
        for (int i = 0; i < POOL_NODES; i++)
        begin
            if (!found && free_map_reg[i])
            begin
                found     = 1'b1;
                free_slot = SW'(i);
            end
        end
    end

    // Free map, head and top value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_map_reg <= '1;
            head_reg     <= NULL_LINK;
            top_reg      <= '0;
        end
        else
        begin
            if (cmd.exec_push && found)
            begin
                free_map_reg[free_slot] <= 1'b0;
                head_reg                <= LW'(free_slot);
                top_reg                 <= value_reg;
            end
            // head slot is freed on the same edge the head moves on
            if (cmd.pop_link)
            begin
                free_map_reg[head_idx] <= 1'b1;
                head_reg <= next_null ? NULL_LINK : link_rd_reg;
            end
            if (cmd.pop_val)
            begin
                top_reg <= head_null ? 32'sd0 : $signed(val_rd_reg);
            end
        end
    end

    // Node memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.exec_push && found)
        begin
            value_mem[free_slot] <= value_reg;
            link_mem[free_slot]  <= head_reg;
        end
        if (cmd.pop_start && !head_null)
        begin
            link_rd_reg <= link_mem[head_idx];
        end
        if (cmd.pop_link && !next_null)
        begin
            val_rd_reg <= value_mem[link_rd_reg[SW-1:0]];
        end
    end

    // Transaction capture, result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg  <= mode;
            value_reg <= push_value;
        end
        if (cmd.exec_push)
        begin
            res_status_reg <= found ? STATUS_DONE : STATUS_FULL;
            res_slot_reg   <= found ? free_slot : '0;
        end
        if (cmd.pop_start)
        begin
            res_status_reg <= head_null ? STATUS_EMPTY : STATUS_DONE;
            res_slot_reg   <= head_null ? '0 : head_idx;
        end
        if (cmd.emit_res)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= slot_ext[2:0];
            out_empty_reg  <= head_null;
            out_top_reg    <= top_reg;
        end
    end

    assign status     = out_status_reg;
    assign slot_used  = out_slot_reg;
    assign list_empty = out_empty_reg;
    assign top_value  = out_top_reg;

    // The list is empty exactly when every slot is free
    a_empty_pool: assert property (@(posedge clk) disable iff (!rst_n)
        head_null == (&free_map_reg))
        else $error("head and free map disagree");

    // A dropped push leaves the pool untouched
    a_full_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec_push && !found) |=> ($stable(free_map_reg) && $stable(head_reg)))
        else $error("pool changed on a dropped push");

    // A successful push leaves a nonempty list topped with the pushed value
    a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec_push && found) |=> (!head_null && top_reg == $past(value_reg)))
        else $error("push did not update head");

    // Push only executes for a push transaction
    a_push_mode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec_push |-> (mode_reg == MODE_PUSH))
        else $error("push executed for a pop transaction");

endmodule

FILE: hdl/pooled_linked_stack_unit.sv
// Top level of the pooled linked stack: controller plus datapath.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_ready, mode,        | in
//          | push_value                       |
//  output  | out_valid, out_ready, status,    | out
//          | slot_used, list_empty, top_value |
//
// A push steps through accept, allocate and respond; its result is valid once
// respond loads the output register. A pop steps through accept, link read, head
// advance with value read, top load and respond, as the link and value memories
// have registered reads. An empty pop goes from link read straight to respond.
// Reset (rst_n low) frees every slot and empties the list at once.
// A stalled output holds its transaction; the next input is accepted once the
// result sits in the output register.
`timescale 1ns / 1ps

module pooled_linked_stack_unit
    import pls_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic signed [31:0] push_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [2:0]         slot_used,
    output logic               list_empty,
    output logic signed [31:0] top_value
);

    cmd_t  cmd;
    stat_t stat;

    pls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pls_datapath #(
        .POOL_NODES (POOL_NODES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .mode       (mode),
        .push_value (push_value),
        .status     (status),
        .slot_used  (slot_used),
        .list_empty (list_empty),
        .top_value  (top_value)
    );

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the pooled linked stack unit.
`timescale 1ns / 1ps

module tb_top
    import pls_pkg::*;
();

    localparam int SLOTS       = POOL_NODES_DEF;
    localparam int NIL         = SLOTS;
    localparam int RAND_ITEMS  = 1620;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    // One response transaction as seen on the output channel
    typedef struct packed {
        logic [1:0]         status;
        logic [2:0]         slot;
        logic               empty;
        logic signed [31:0] top;
    } stack_resp_t;

    // One row of the directed sequence
    typedef struct {
        logic               op;
        logic signed [31:0] val;
        bit                 fixed;
        stack_resp_t        want;
    } dir_row_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic               mode       = MODE_PUSH;
    logic signed [31:0] push_value = 32'sd0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [1:0]         status;
    logic [2:0]         slot_used;
    logic               list_empty;
    logic signed [31:0] top_value;

    // Shadow copy of the stack kept by the predictor
    logic [SLOTS-1:0]   shadow_free;
    logic signed [31:0] shadow_val [SLOTS];
    logic [3:0]         shadow_next [SLOTS];
    logic [3:0]         shadow_head;

    stack_resp_t resp_queue[$];
    dir_row_t    dir_rows[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    int hold_token    = 0;
    int hold_seen     = 0;

    pooled_linked_stack_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .slot_used  (slot_used),
        .list_empty (list_empty),
        .top_value  (top_value)
    );

    always #4 clk = ~clk;

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Push/pop predictor: applies one operation to the shadow stack
    task automatic stack_apply(input logic op, input logic signed [31:0] val,
                               output stack_resp_t resp);
        int   pick;
        logic [3:0] old;
        pick = NIL;
        resp.status = STATUS_DONE;
        resp.slot   = 3'd0;
        if (op == MODE_PUSH)
        begin
            for (int i = SLOTS - 1; i >= 0; i--)
                if (shadow_free[i])
                    pick = i;
            if (pick == NIL)
                resp.status = STATUS_FULL;
            else
            begin
                shadow_free[pick] = 1'b0;
                shadow_val[pick]  = val;
                shadow_next[pick] = shadow_head;
                shadow_head       = 4'(pick);
                resp.slot         = 3'(pick);
            end
        end
        else if (shadow_head == 4'(NIL))
            resp.status = STATUS_EMPTY;
        else
        begin
            old                = shadow_head;
            shadow_head        = shadow_next[old];
            shadow_free[old]   = 1'b1;
            shadow_val[old]    = 32'sd0;
            shadow_next[old]   = 4'(NIL);
            resp.slot          = old[2:0];
        end
        resp.empty = (shadow_head == 4'(NIL));
        resp.top   = resp.empty ? 32'sd0 : shadow_val[shadow_head];
    endtask

    task automatic add_row(input logic op, input logic signed [31:0] val, input bit fixed,
                           input logic [1:0] st, input logic [2:0] sl, input logic em,
                           input logic signed [31:0] tp);
        dir_row_t row;
        row.op   = op;
        row.val  = val;
        row.fixed = fixed;
        row.want = '{st, sl, em, tp};
        dir_rows.push_back(row);
    endtask

    // Offer one transaction, wait for acceptance, queue its expected response
    task automatic send_op(input logic op, input logic signed [31:0] val,
                           input bit fixed, input stack_resp_t want);
        stack_resp_t pred;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        push_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        stack_apply(op, val, pred);
        resp_queue.push_back(fixed ? want : pred);
    endtask

    // Random operand: mostly full random, sometimes an extreme
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $signed($urandom());
        endcase
    endfunction

    // Output ready generation, including the long hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Response checker
    always @(posedge clk)
    begin
        stack_resp_t got;
        stack_resp_t exp_resp;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{status, slot_used, list_empty, top_value};
            if (resp_queue.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected response st=%0d slot=%0d empty=%0b top=%h",
                             got.status, got.slot, got.empty, got.top);
            end
            else
            begin
                exp_resp = resp_queue.pop_front();
                if (got !== exp_resp)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display({"mismatch exp st=%0d slot=%0d empty=%0b top=%h",
                                  " / got st=%0d slot=%0d empty=%0b top=%h"},
                                 exp_resp.status, exp_resp.slot, exp_resp.empty,
                                 exp_resp.top,
                                 got.status, got.slot, got.empty, got.top);
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        stack_resp_t none;
        int          push_pct;
        logic        op;
        none = '0;

        shadow_free = '1;
        shadow_head = 4'(NIL);
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_val[i]  = 32'sd0;
            shadow_next[i] = 4'(NIL);
        end

        // Directed: empty pop, extremes, fill to full, reuse, drain past empty
        add_row(MODE_POP,  32'sd0,         1'b1, STATUS_EMPTY, 3'd0, 1'b1, 32'sd0);
        add_row(MODE_PUSH, 32'sh7FFF_FFFF, 1'b1, STATUS_DONE,  3'd0, 1'b0, 32'sh7FFF_FFFF);
        add_row(MODE_PUSH, 32'sh8000_0000, 1'b1, STATUS_DONE,  3'd1, 1'b0, 32'sh8000_0000);
        add_row(MODE_POP,  32'sh5A5A_5A5A, 1'b1, STATUS_DONE,  3'd1, 1'b0, 32'sh7FFF_FFFF);
        add_row(MODE_POP,  -32'sd1,        1'b1, STATUS_DONE,  3'd0, 1'b1, 32'sd0);
        add_row(MODE_POP,  32'sd0,         1'b1, STATUS_EMPTY, 3'd0, 1'b1, 32'sd0);
        add_row(MODE_PUSH, 32'sd0,         1'b0, STATUS_DONE,  3'd0, 1'b0, 32'sd0);
        add_row(MODE_PUSH, -32'sd1,        1'b0, STATUS_DONE,  3'd0, 1'b0, 32'sd0);
        add_row(MODE_PUSH, 32'sd1,         1'b0, STATUS_DONE,  3'd0, 1'b0, 32'sd0);
        add_row(MODE_PUSH, 32'sh5555_5555, 1'b0, STATUS_DONE,  3'd0, 1'b0, 32'sd0);
        add_row(MODE_PUSH, 32'shAAAA_AAAA, 1'b0, STATUS_DONE,  3'd0, 1'b0, 32'sd0);
        add_row(MODE_PUSH, 32'sh8000_0001, 1'b0, STATUS_DONE,  3'd0, 1'b0, 32'sd0);
        add_row(MODE_PUSH, 32'sh7FFF_FFFE, 1'b0, STATUS_DONE,  3'd0, 1'b0, 32'sd0);
        add_row(MODE_PUSH, 32'sh1234_5678, 1'b0, STATUS_DONE,  3'd0, 1'b0, 32'sd0);
        // pool is full: push dropped, head unchanged
        add_row(MODE_PUSH, 32'shDEAD_BEEF, 1'b1, STATUS_FULL,  3'd0, 1'b0, 32'sh1234_5678);
        add_row(MODE_POP,  32'sd0,         1'b0, STATUS_DONE,  3'd0, 1'b0, 32'sd0);
        add_row(MODE_POP,  32'sd0,         1'b0, STATUS_DONE,  3'd0, 1'b0, 32'sd0);
        add_row(MODE_PUSH, 32'sh0F0F_0F0F, 1'b0, STATUS_DONE,  3'd0, 1'b0, 32'sd0);
        for (int i = 0; i < 7; i++)
            add_row(MODE_POP, 32'sd0, 1'b0, STATUS_DONE, 3'd0, 1'b0, 32'sd0);
        add_row(MODE_POP,  32'sd0,         1'b1, STATUS_EMPTY, 3'd0, 1'b1, 32'sd0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_op(dir_rows[i].op, dir_rows[i].val, dir_rows[i].fixed, dir_rows[i].want);

        // Random: three idling phases, push bias changes every burst of 16
        push_pct = 50;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == 0)
            begin
                send_idle_pct = 28;
                recv_idle_pct = 81;
            end
            else if (n == RAND_ITEMS / 3)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 28;
            end
            else if (n == 2 * RAND_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_token <= hold_token + 1;  // long output stall, input keeps offering
            end
            if (n % 16 == 0)
                case ($urandom_range(0, 3))
                    0:       push_pct = 90;
                    1:       push_pct = 10;
                    default: push_pct = $urandom_range(30, 70);
                endcase
            op = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
            send_op(op, pick_value(), 1'b0, none);
        end
        in_valid <= 1'b0;

        // Drain outstanding responses, then give the pipeline time to misbehave
        while (resp_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0 && resp_queue.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
hdl/pls_pkg.sv
hdl/pls_ctrl.sv
hdl/pls_datapath.sv
hdl/pooled_linked_stack_unit.sv
verif/tb_top.sv
